// ===== sv/square_brush_pixel_writer_defines.svh =====
// Assertion macros for the square brush pixel writer.
// Included by the top level; expects clk and arst_n in scope.
`ifndef SQUARE_BRUSH_PIXEL_WRITER_DEFINES_SVH
`define SQUARE_BRUSH_PIXEL_WRITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBPW_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("square brush pixel writer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SBPW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("square brush pixel writer: next-cycle check failed");

`endif

// ===== sv/sbpw_pkg.sv =====
// Shared types and constants for the square brush pixel writer.
// No dependencies.
package sbpw_pkg;

	// Image and brush limits.
	localparam int unsigned MAX_WIDTH  = 1024;
	localparam int unsigned MAX_HEIGHT = 1024;
	localparam int unsigned MAX_BRUSH  = 7;
	localparam int unsigned HALF_MAX   = MAX_BRUSH / 2;

	// Field widths.
	localparam int unsigned COORD_W  = 16;
	localparam int unsigned BRUSH_W  = 3;
	localparam int unsigned COLOR_W  = 8;
	localparam int unsigned DIM_W    = 11;
	localparam int unsigned ADDR_W   = 20;
	localparam int unsigned HALF_W   = BRUSH_W - 1;
	localparam int unsigned CHECK_W  = COORD_W + 2;
	localparam int unsigned PROD_W   = 2 * DIM_W;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = DIM_W;
	localparam int unsigned IN_DATA_W  = 2 * COORD_W;
	localparam int unsigned OUT_DATA_W = ((ADDR_W + COLOR_W + 7) / 8) * 8;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRUSH_SIZE   = 2'd0,
		REG_PAINT_COLOR  = 2'd1,
		REG_IMAGE_WIDTH  = 2'd2,
		REG_IMAGE_HEIGHT = 2'd3
	} cfg_reg_t;

	// Limit a configured dimension to the given maximum.
	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
			input int unsigned lim);
		logic [DIM_W-1:0] r;
		r = v;
		if (32'(v) > lim) begin
			r = DIM_W'(lim);
		end
		return r;
	endfunction

endpackage

// ===== sv/square_brush_pixel_writer.sv =====
// Square brush pixel writer: top level, sequencer and shared address adder.
// Depends on sbpw_pkg and square_brush_pixel_writer_defines.svh.
//
// Usage: each transfer on the s_axis channel carries one point (x, y). The
// block answers with the frame-buffer writes of a square brush of side
// 2*(brush_size/2)+1 centred on that point, top row first, left to right,
// one write per m_axis transfer, tlast set on the final write. A point whose
// square would leave the configured image produces no writes at all.
// The point is captured on its transfer, checked against the image in ST_CHECK,
// its first row address is formed by the multiplier in ST_MUL, and ST_EMIT then
// steps the single address adder through the n writes (1, 9, 25 or 49), one
// pixel per cycle while the receiver does not stall. A skipped point returns to
// idle from ST_CHECK. No new point is taken before the current one is through.
// s_axis_tready is high only while no point is in progress.
// When the receiver stalls, the write held in the output register waits and
// the sequencer waits with it; nothing is lost or repeated.
// Reset brings the block idle with brush_size 1, paint_color 0 and a 1024 by
// 1024 image. Configuration is to be written only while idle; the block does not enforce it.
`include "square_brush_pixel_writer_defines.svh"

module square_brush_pixel_writer
	import sbpw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Point input. tdata: point_x [15:0], point_y [31:16].
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// Write output. tdata: pixel_address [19:0], pixel_value [27:20], zeros above.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic [BRUSH_W-1:0]   brush_q;
	logic [COLOR_W-1:0]   color_q;
	logic [DIM_W-1:0]     width_q;
	logic [DIM_W-1:0]     height_q;
	logic [COORD_W-1:0]   held_x_q;
	logic [COORD_W-1:0]   held_y_q;
	logic [DIM_W-1:0]     start_x_q;
	logic [DIM_W-1:0]     start_y_q;
	logic [ADDR_W-1:0]    row_step_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [BRUSH_W-1:0]   row_q;
	logic [BRUSH_W-1:0]   col_q;
	logic                 m_valid_q;
	logic [ADDR_W-1:0]    m_addr_q;
	logic [COLOR_W-1:0]   m_color_q;
	logic                 m_last_q;

	logic [HALF_W-1:0]    half_c;
	logic [BRUSH_W-1:0]   span_c;
	logic [DIM_W-1:0]     w_c;
	logic [DIM_W-1:0]     h_c;
	logic signed [CHECK_W-1:0] x_lo_c, x_hi_c, y_lo_c, y_hi_c;
	logic                 fit_c;
	logic [PROD_W-1:0]    prod_c;
	logic                 row_end_c;
	logic                 last_c;
	logic                 out_free_c;
	logic                 load_c;
	logic [ADDR_W-1:0]    addr_next_c;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brush_q  <= BRUSH_W'(1);
			color_q  <= '0;
			width_q  <= DIM_W'(1024);
			height_q <= DIM_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BRUSH_SIZE:   brush_q  <= cfg_data[BRUSH_W-1:0];
				REG_PAINT_COLOR:  color_q  <= cfg_data[COLOR_W-1:0];
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
			endcase
		end
	end

	// Brush half width and saturated image size.
	always_comb begin
		half_c = brush_q[BRUSH_W-1:1];
		if (32'(half_c) > HALF_MAX) begin
			half_c = HALF_W'(HALF_MAX);
		end
		span_c = {half_c, 1'b0};
		w_c    = sat_dim(width_q, MAX_WIDTH);
		h_c    = sat_dim(height_q, MAX_HEIGHT);
	end

	// Bounds check of the whole square against the image.
	always_comb begin
		x_lo_c = CHECK_W'($signed(held_x_q)) - $signed(CHECK_W'(half_c));
		x_hi_c = CHECK_W'($signed(held_x_q)) + $signed(CHECK_W'(half_c));
		y_lo_c = CHECK_W'($signed(held_y_q)) - $signed(CHECK_W'(half_c));
		y_hi_c = CHECK_W'($signed(held_y_q)) + $signed(CHECK_W'(half_c));
		fit_c  = !x_lo_c[CHECK_W-1] && !y_lo_c[CHECK_W-1]
			&& (x_hi_c < $signed(CHECK_W'(w_c)))
			&& (y_hi_c < $signed(CHECK_W'(h_c)));
	end

	// First address of the square: top row times stride.
	assign prod_c = start_y_q * w_c;

	// Shared adder: one step right, or down to the start of the next row.
	always_comb begin
		row_end_c   = (col_q == span_c);
		last_c      = row_end_c && (row_q == span_c);
		addr_next_c = addr_q + (row_end_c ? row_step_q : ADDR_W'(1));
		out_free_c  = !m_valid_q || m_axis_tready;
		load_c      = (state_q == ST_EMIT) && out_free_c;
	end

	// Point capture register.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			held_x_q <= s_axis_tdata[COORD_W-1:0];
			held_y_q <= s_axis_tdata[2*COORD_W-1:COORD_W];
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			start_x_q  <= '0;
			start_y_q  <= '0;
			row_step_q <= '0;
			addr_q     <= '0;
			row_q      <= '0;
			col_q      <= '0;
			m_valid_q  <= 1'b0;
			m_addr_q   <= '0;
			m_color_q  <= '0;
			m_last_q   <= 1'b0;
		end else begin
			if (m_axis_tready && !load_c) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					start_x_q  <= x_lo_c[DIM_W-1:0];
					start_y_q  <= y_lo_c[DIM_W-1:0];
					row_step_q <= ADDR_W'(w_c) - ADDR_W'(span_c);
					row_q      <= '0;
					col_q      <= '0;
					state_q    <= fit_c ? ST_MUL : ST_IDLE;
				end
				ST_MUL: begin
					addr_q  <= prod_c[ADDR_W-1:0] + ADDR_W'(start_x_q);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free_c) begin
						m_valid_q <= 1'b1;
						m_addr_q  <= addr_q;
						m_color_q <= color_q;
						m_last_q  <= last_c;
						addr_q    <= addr_next_c;
						if (last_c) begin
							state_q <= ST_IDLE;
						end else if (row_end_c) begin
							col_q <= '0;
							row_q <= row_q + BRUSH_W'(1);
						end else begin
							col_q <= col_q + BRUSH_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tdata  = {(OUT_DATA_W - ADDR_W - COLOR_W)'(0), m_color_q, m_addr_q};

	// One point at a time: a point transfer closes the input until done.
	`SBPW_ASSERT_NEXT(a_one_point, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// The scan position never leaves the square while writes are produced.
	`SBPW_ASSERT_SAME(a_scan_bound, state_q == ST_EMIT, row_q <= span_c && col_q <= span_c)
	// Loading the final write ends the point and marks it as last.
	`SBPW_ASSERT_NEXT(a_last_ends, load_c && last_c, state_q == ST_IDLE && m_last_q)

endmodule

// ===== bench/sbpw_stream_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the square brush pixel writer: mirrors the configuration
// registers, predicts the brush writes of each accepted point and checks every
// write transfer against them. Depends on sbpw_pkg.
module sbpw_stream_checker
	import sbpw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// tdata: point_x [15:0], point_y [31:16].
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata: pixel_address [19:0], pixel_value [27:20], zeros above.
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  m_axis_tlast,
	output int                    write_backlog,
	output int                    error_count
);

	localparam int PAD_W = OUT_DATA_W - ADDR_W - COLOR_W;

	typedef struct {
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] value;
		logic               last;
	} pixel_write_t;

	pixel_write_t brush_writes_q[$];

	// Local copy of the configuration registers.
	logic [BRUSH_W-1:0] brush_size_r;
	logic [COLOR_W-1:0] paint_color_r;
	logic [DIM_W-1:0]   image_width_r;
	logic [DIM_W-1:0]   image_height_r;

	// Queue every write of the square brush around one point, or nothing when
	// any pixel of the square would leave the image.
	function automatic void stamp_brush(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py);
		int half, w, h, xi, yi, r, c, addr;
		pixel_write_t wr;
		half = int'(brush_size_r) / 2;
		if (half > int'(HALF_MAX))
			half = int'(HALF_MAX);
		w = int'(image_width_r);
		if (w > int'(MAX_WIDTH))
			w = int'(MAX_WIDTH);
		h = int'(image_height_r);
		if (h > int'(MAX_HEIGHT))
			h = int'(MAX_HEIGHT);
		xi = int'(px);
		yi = int'(py);
		if (xi - half < 0 || yi - half < 0 || xi + half >= w || yi + half >= h)
			return;
		for (r = -half; r <= half; r++) begin
			for (c = -half; c <= half; c++) begin
				addr = (xi + c) + (yi + r) * w;
				wr.addr = ADDR_W'(addr);
				wr.value = paint_color_r;
				wr.last = (r == half && c == half);
				brush_writes_q.push_back(wr);
			end
		end
	endfunction

	function automatic void report_mismatch(input string what, input logic [31:0] expv,
			input logic [31:0] actv);
		error_count++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, expv, actv);
	endfunction

	// Sample both channels and the register port at each rising edge.
	always @(posedge clk or negedge arst_n) begin : watch
		pixel_write_t exp_wr;
		if (!arst_n) begin
			brush_size_r = BRUSH_W'(1);
			paint_color_r = '0;
			image_width_r = DIM_W'(1024);
			image_height_r = DIM_W'(1024);
			brush_writes_q.delete();
			write_backlog <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
				REG_BRUSH_SIZE: begin
					brush_size_r = cfg_data[BRUSH_W-1:0];
				end
				REG_PAINT_COLOR: begin
					paint_color_r = cfg_data[COLOR_W-1:0];
				end
				REG_IMAGE_WIDTH: begin
					image_width_r = cfg_data[DIM_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					image_height_r = cfg_data[DIM_W-1:0];
				end
				default: begin
				end
				endcase
			end

			if (s_axis_tvalid && s_axis_tready)
				stamp_brush(s_axis_tdata[COORD_W-1:0], s_axis_tdata[2*COORD_W-1:COORD_W]);

			// Each write transfer is matched against the oldest predicted write.
			if (m_axis_tvalid && m_axis_tready) begin
				if (brush_writes_q.size() == 0) begin
					error_count++;
					$display("%0t: pixel write mismatch, expected none, got address %0d",
						$time, m_axis_tdata[ADDR_W-1:0]);
				end else begin
					exp_wr = brush_writes_q.pop_front();
					if (m_axis_tdata[ADDR_W-1:0] !== exp_wr.addr)
						report_mismatch("pixel_address", 32'(exp_wr.addr),
							32'(m_axis_tdata[ADDR_W-1:0]));
					if (m_axis_tdata[ADDR_W+COLOR_W-1:ADDR_W] !== exp_wr.value)
						report_mismatch("pixel_value", 32'(exp_wr.value),
							32'(m_axis_tdata[ADDR_W+COLOR_W-1:ADDR_W]));
					if (m_axis_tlast !== exp_wr.last)
						report_mismatch("last_write", 32'(exp_wr.last), 32'(m_axis_tlast));
					if (m_axis_tdata[OUT_DATA_W-1:ADDR_W+COLOR_W] !== '0)
						report_mismatch("tdata padding", 0,
							32'(m_axis_tdata[OUT_DATA_W-1:OUT_DATA_W-PAD_W]));
				end
			end
			write_backlog <= brush_writes_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the square brush pixel writer bench: clock, reset, register writes,
// point stimulus, output back-pressure and the verdict.
// Depends on sbpw_pkg, square_brush_pixel_writer and sbpw_stream_checker.
module tb_top;
	import sbpw_pkg::*;

	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_POINTS = 45;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// tdata: point_x [15:0], point_y [31:16].
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// tdata: pixel_address [19:0], pixel_value [27:20], zeros above.
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	int write_backlog;
	int error_count;
	bit rx_stall_on;
	bit tx_gap_on;
	bit hold_req;
	int cur_width;
	int cur_height;

	always #10 clk = ~clk;

	square_brush_pixel_writer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	sbpw_stream_checker u_score (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.write_backlog (write_backlog),
		.error_count   (error_count)
	);

	// Hard stop in case the block hangs.
	initial begin : run_limit
		#100_000_000;
		$display("FAIL");
		$finish;
	end

	// Most idle stretches are short, a few are long.
	function automatic int pick_gap();
		int gap;
		gap = ($urandom_range(0, 19) < 17) ? $urandom_range(1, 3) : $urandom_range(10, 60);
		return gap;
	endfunction

	// Image dimension for a random phase, with the degenerate and saturating
	// values mixed in.
	function automatic int pick_dim();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return 0;
		if (sel <= 3)
			return $urandom_range(1, 8);
		if (sel <= 5)
			return 1024;
		if (sel <= 7)
			return $urandom_range(1025, 2047);
		return $urandom_range(9, 1023);
	endfunction

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin : write_sink
		int gap;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				gap = pick_gap();
				repeat (gap) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Offer one point and wait for its transfer.
	task automatic send_point(input int px, input int py);
		int gap;
		if (tx_gap_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = pick_gap();
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {COORD_W'(py), COORD_W'(px)};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Mostly points inside the image, some around its edges, some anywhere.
	task automatic send_random_point();
		int wlim, hlim, sel, x, y;
		wlim = (cur_width > int'(MAX_WIDTH)) ? int'(MAX_WIDTH) : cur_width;
		hlim = (cur_height > int'(MAX_HEIGHT)) ? int'(MAX_HEIGHT) : cur_height;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			x = $urandom_range(0, (wlim > 0) ? wlim - 1 : 0);
			y = $urandom_range(0, (hlim > 0) ? hlim - 1 : 0);
		end else if (sel < 85) begin
			x = int'($urandom_range(0, wlim + 8)) - 4;
			y = int'($urandom_range(0, hlim + 8)) - 4;
		end else begin
			x = $urandom_range(0, 65535);
			y = $urandom_range(0, 65535);
		end
		send_point(x, y);
	endtask

	// Stop offering points and let every predicted write come out, then give
	// a skipped point time to finish.
	task automatic drain_writes();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (write_backlog != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
	endtask

	task automatic set_config(input int brush, input int color, input int width,
			input int height);
		drain_writes();
		write_reg(REG_BRUSH_SIZE, brush);
		write_reg(REG_PAINT_COLOR, color);
		write_reg(REG_IMAGE_WIDTH, width);
		write_reg(REG_IMAGE_HEIGHT, height);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_width = width;
		cur_height = height;
	endtask

	// Reset, directed points under a few settings, then random phases.
	initial begin : stimulus
		int ph, k, brush, width, height;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_BRUSH_SIZE;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		rx_stall_on = 1'b1;
		tx_gap_on = 1'b1;
		hold_req = 1'b0;
		cur_width = 1024;
		cur_height = 1024;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: single pixel brush on a full size image.
		send_point(0, 0);
		send_point(1023, 1023);
		send_point(1024, 0);
		send_point(0, 1024);
		send_point(-1, 5);
		send_point(-32768, -32768);
		send_point(32767, 32767);
		send_point(-1, -1);
		send_point(32767, -32768);

		// Largest brush, touching each edge and just crossing the left, right and bottom edges.
		set_config(7, 255, 1024, 1024);
		send_point(3, 3);
		send_point(2, 3);
		send_point(1020, 1020);
		send_point(1021, 1020);
		send_point(512, 1021);

		// Zero size brush with zero width, then a size four brush with zero height.
		set_config(0, 8'h55, 0, 1024);
		send_point(5, 5);
		set_config(4, 8'hAA, 2047, 0);
		send_point(5, 5);

		// One pixel image: only the single pixel brush fits.
		set_config(4, 1, 1, 1);
		send_point(0, 0);
		set_config(1, 2, 1, 1);
		send_point(0, 0);

		// Oversized width and height are limited, stride included.
		set_config(2, 3, 2047, 2047);
		send_point(1022, 1022);
		send_point(1023, 5);

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			brush = $urandom_range(0, 7);
			width = pick_dim();
			height = pick_dim();
			if (ph == 1) begin
				brush = 7;
				width = 1024;
				height = 1024;
			end
			set_config(brush, $urandom_range(0, 255), width, height);
			rx_stall_on = (ph % 3 != 2);
			tx_gap_on = (ph % 3 != 2);
			if (ph == 1)
				hold_req = 1'b1;
			for (k = 0; k < PHASE_POINTS; k++) begin
				if (ph == 4 && k == PHASE_POINTS / 2)
					drain_writes();
				send_random_point();
			end
		end

		drain_writes();
		if (error_count == 0 && write_backlog == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
